/* rtl/core/slist_pkg.sv */
// Package for the sequential list engine.
// Holds the request and response payload types and the controller/datapath interface.
// No dependencies.
package slist_pkg;

  // Request codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_LOCATE = 2'd3
  } action_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    action_e            action;
    logic [4:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] read_value;
    logic [4:0]         found_position;
    logic [4:0]         list_length;
  } rsp_t;

  // Pointer update
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_COUNT,
    PTR_POSM1,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  // Memory read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_PTRM1,
    RD_PTRP1
  } rd_op_e;

  // Memory write data select (address is always the pointer)
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_VAL
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    ptr_op_e ptr_op;
    rd_op_e  rd_op;
    wr_op_e  wr_op;
    cnt_op_e cnt_op;
    logic    set_status;
    status_e status;
    logic    set_rv;
    logic    set_found;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_e action;
    logic    ins_bad;
    logic    full;
    logic    pos_bad;
    logic    ins_more;
    logic    del_more;
    logic    scan_more;
    logic    match;
  } dp_sts_t;

endpackage

/* rtl/core/slist_dp.sv */
// Datapath of the sequential list engine: entry memory, length, pointer,
// request and result registers. Depends on slist_pkg; driven by slist_ctrl.
module slist_dp #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slist_pkg::req_t  in_req_i,
  input  slist_pkg::dp_cmd_t cmd_i,
  output slist_pkg::dp_sts_t sts_o,
  output slist_pkg::rsp_t  out_rsp_o
);
  import slist_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 5) ? CW : 5) + 1;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata_q;
  action_e            act_q;
  logic [4:0]         pos_q;
  logic signed [31:0] val_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  status_e            status_q;
  logic signed [31:0] rv_q;
  logic [4:0]         found_q;
  rsp_t               out_rsp_q;

  logic [PW-1:0] pos_w, cnt_w, ptr_w, pos_m1_w, ptr_p1_w;
  logic [CW-1:0] ptr_m1, ptr_p1;
  logic [AW-1:0] rd_addr;
  logic [31:0]   wr_data;

  // Widened copies for compares
  assign pos_w    = PW'(pos_q);
  assign cnt_w    = PW'(count_q);
  assign ptr_w    = PW'(ptr_q);
  assign pos_m1_w = pos_w - PW'(1);
  assign ptr_p1_w = ptr_w + PW'(1);
  assign ptr_m1   = ptr_q - 1'b1;
  assign ptr_p1   = ptr_q + 1'b1;

  // Status towards the controller
  always_comb begin
    sts_o.action    = act_q;
    sts_o.ins_bad   = (pos_q == 5'd0) || (pos_w > cnt_w + PW'(1));
    sts_o.full      = cnt_w >= PW'(DEPTH);
    sts_o.pos_bad   = (pos_q == 5'd0) || (pos_w > cnt_w);
    sts_o.ins_more  = ptr_w >= pos_w;
    sts_o.del_more  = ptr_p1_w < cnt_w;
    sts_o.scan_more = ptr_w < cnt_w;
    sts_o.match     = rdata_q == val_q;
  end

  // Pointer and length next values
  always_comb begin
    case (cmd_i.ptr_op)
      PTR_COUNT: ptr_d = count_q;
      PTR_POSM1: ptr_d = pos_m1_w[CW-1:0];
      PTR_ZERO:  ptr_d = '0;
      PTR_INC:   ptr_d = ptr_p1;
      PTR_DEC:   ptr_d = ptr_m1;
      default:   ptr_d = ptr_q;
    endcase
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + 1'b1;
      CNT_DEC: count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  // Memory address and data selection
  always_comb begin
    case (cmd_i.rd_op)
      RD_PTRM1: rd_addr = ptr_m1[AW-1:0];
      RD_PTRP1: rd_addr = ptr_p1[AW-1:0];
      default:  rd_addr = ptr_q[AW-1:0];
    endcase
    wr_data = (cmd_i.wr_op == WR_VAL) ? val_q : rdata_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_op != WR_NONE) begin
      mem[ptr_q[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_op != RD_NONE) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= in_req_i.action;
      pos_q    <= in_req_i.position;
      val_q    <= in_req_i.value;
      status_q <= ST_OK;
      rv_q     <= '0;
      found_q  <= '0;
    end else begin
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.set_rv) begin
        rv_q <= rdata_q;
      end
      if (cmd_i.set_found) begin
        found_q <= ptr_p1_w[4:0];
      end
    end
    if (cmd_i.out_load) begin
      out_rsp_q.status         <= status_q;
      out_rsp_q.read_value     <= rv_q;
      out_rsp_q.found_position <= found_q;
      out_rsp_q.list_length    <= cnt_w[4:0];
    end
  end

  assign out_rsp_o = out_rsp_q;

`ifndef SYNTHESIS
  // Length never passes the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list length above capacity");

  // Growth only with room left, shrink only from a non-empty list
  a_inc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == CNT_INC |-> count_q < CW'(DEPTH))
    else $error("insert into full list");
  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == CNT_DEC |-> count_q != '0)
    else $error("delete from empty list");

  // Writes stay inside the live part of the list plus the new slot
  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_op != WR_NONE |-> (ptr_q <= count_q) && (ptr_q < CW'(DEPTH)))
    else $error("memory write outside list");

  // A shift write uses data read in the previous cycle
  a_shift_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_op == WR_SHIFT |-> $past(cmd_i.rd_op) != RD_NONE)
    else $error("shift write without a preceding read");
`endif

endmodule

/* rtl/core/slist_ctrl.sv */
// Controller of the sequential list engine: request sequencing state machine
// and result valid. Depends on slist_pkg; drives slist_dp.
module slist_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  slist_pkg::dp_sts_t  sts_i,
  output slist_pkg::dp_cmd_t  cmd_o
);
  import slist_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_GET_RD,
    S_GET_WAIT,
    S_LOC_CHK,
    S_LOC_CMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.ptr_op = PTR_HOLD;
    cmd_o.rd_op  = RD_NONE;
    cmd_o.wr_op  = WR_NONE;
    cmd_o.cnt_op = CNT_HOLD;
    cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.action)
          ACT_INSERT: begin
            if (sts_i.ins_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_POS;
              state_d = S_DONE;
            end else if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
              state_d = S_DONE;
            end else begin
              cmd_o.ptr_op = PTR_COUNT;
              state_d = S_INS_CHK;
            end
          end
          ACT_DELETE, ACT_GET: begin
            if (sts_i.pos_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_POS;
              state_d = S_DONE;
            end else begin
              cmd_o.ptr_op = PTR_POSM1;
              state_d = (sts_i.action == ACT_DELETE) ? S_DEL_CHK : S_GET_RD;
            end
          end
          default: begin
            cmd_o.ptr_op = PTR_ZERO;
            state_d = S_LOC_CHK;
          end
        endcase
      end
      // Move entries up from the tail, then drop the new value in
      S_INS_CHK: begin
        if (sts_i.ins_more) begin
          cmd_o.rd_op = RD_PTRM1;
          state_d = S_INS_WR;
        end else begin
          cmd_o.wr_op  = WR_VAL;
          cmd_o.cnt_op = CNT_INC;
          state_d = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_op  = WR_SHIFT;
        cmd_o.ptr_op = PTR_DEC;
        state_d = S_INS_CHK;
      end
      // Move later entries down over the removed one
      S_DEL_CHK: begin
        if (sts_i.del_more) begin
          cmd_o.rd_op = RD_PTRP1;
          state_d = S_DEL_WR;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
          state_d = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_op  = WR_SHIFT;
        cmd_o.ptr_op = PTR_INC;
        state_d = S_DEL_CHK;
      end
      S_GET_RD: begin
        cmd_o.rd_op = RD_PTR;
        state_d = S_GET_WAIT;
      end
      S_GET_WAIT: begin
        cmd_o.set_rv = 1'b1;
        state_d = S_DONE;
      end
      // Linear scan, first match wins
      S_LOC_CHK: begin
        if (sts_i.scan_more) begin
          cmd_o.rd_op = RD_PTR;
          state_d = S_LOC_CMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LOC_CMP: begin
        if (sts_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d = S_LOC_CHK;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on load, cleared on transfer
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A request is taken only by an idle sequencer, and it leaves idle next cycle
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_DECODE)
    else $error("accepted request not decoded");

  // The result register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten");

  // Every completed request hands a result over and returns to idle
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("result load without valid");
`endif

endmodule

/* rtl/core/sequential_list_engine.sv */
// Top level of the sequential list engine.
// Depends on slist_pkg, slist_ctrl and slist_dp.
//
// Ordered list of up to DEPTH signed 32-bit entries held in a single-port-style
// memory (one write, one registered read per cycle), stepped by a sequencer.
// Requests are handled one at a time; a result is registered and may wait for
// the receiver while the next request is already taken. Insert moves each entry
// from the tail down to the position up by one, then writes the new value.
// Delete moves each entry after the position down by one. Get reads one entry.
// Locate scans from the first entry until a match or the end of the list.
// Bad-position and full requests go straight to the result. A result that is
// still waiting holds the sequencer in its last state until the slot frees.
// The next request can be taken in the cycle after the result is loaded. The
// per-entry cost comes from the read-then-write of the shared memory port.
// No clearing pass is needed after reset: entries past the length are never read.
module sequential_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  slist_pkg::req_t   in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output slist_pkg::rsp_t   out_rsp_o
);
  import slist_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  slist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule
